FILE: rtl/msbm_pkg.sv
// package for the multi signature byte matcher
// beat structs, command codes and default sizes; no dependencies
package msbm_pkg;

	localparam int NUM_SIGS_DEF    = 8;
	localparam int MAX_SIG_LEN_DEF = 64;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_SET_LEN = 2'd1,
		CMD_SCAN    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [2:0] sig_slot;
		logic [5:0] sig_pos;
		logic [7:0] data_byte;
		logic [6:0] sig_len_in;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  match_slot;
		logic [31:0] start_offset;
		logic [6:0]  match_len;
		logic        last;
	} out_beat_t;

	// command after range checks and length saturation
	typedef struct packed {
		cmd_t       kind;
		logic [2:0] slot;
		logic [5:0] pos;
		logic [7:0] data;
		logic [6:0] len;
	} op_t;

endpackage

FILE: rtl/msbm_front.sv
// front end: takes input beats, drops out-of-range loads and length writes,
// saturates lengths and hands commands to the queue; uses msbm_pkg
module msbm_front import msbm_pkg::*; #(
	parameter int NUM_SIGS    = NUM_SIGS_DEF,
	parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF
) (
	input  logic     in_valid,
	output logic     in_ready,
	input  in_beat_t in_data,
	output logic     push,
	output op_t      op,
	input  logic     q_ready
);

	logic keep;
	logic slot_ok;
	logic pos_ok;
	logic len_big;

	always_comb begin
		slot_ok = 32'(in_data.sig_slot) < 32'(NUM_SIGS);
		pos_ok  = 32'(in_data.sig_pos) < 32'(MAX_SIG_LEN);
		len_big = 32'(in_data.sig_len_in) > 32'(MAX_SIG_LEN);
		unique case (in_data.cmd)
			CMD_LOAD: begin
				keep = slot_ok && pos_ok;
			end
			CMD_SET_LEN: begin
				keep = slot_ok;
			end
			default: begin
				keep = 1'b1;
			end
		endcase
		op.kind = in_data.cmd;
		op.slot = in_data.sig_slot;
		op.pos  = in_data.sig_pos;
		op.data = in_data.data_byte;
		op.len  = len_big ? 7'(MAX_SIG_LEN) : in_data.sig_len_in;
	end

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready && keep;

endmodule

FILE: rtl/msbm_fifo.sv
// short command queue between front and back end
// depth from msbm_pkg
module msbm_fifo import msbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  wr_op,
	output logic ready,
	output logic valid,
	output op_t  rd_op,
	input  logic pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign ready   = cnt_q != CW'(QUEUE_DEPTH);
	assign valid   = cnt_q != '0;
	assign rd_op   = mem_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/msbm_back.sv
// back end: signature store, lengths, history window and the compare unit
// one signature byte compared per cycle; uses msbm_pkg
module msbm_back import msbm_pkg::*; #(
	parameter int NUM_SIGS    = NUM_SIGS_DEF,
	parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  op_t       q_op,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam int NS  = (NUM_SIGS > 8) ? 8 : NUM_SIGS;
	localparam int SIW = (NS > 1) ? $clog2(NS) : 1;
	localparam int HAW = $clog2(MAX_SIG_LEN);
	localparam int HD  = 2 ** HAW;
	localparam int SD  = 2 ** (SIW + HAW);
	localparam int LW  = $clog2(MAX_SIG_LEN + 1);

	typedef enum logic [4:0] {
		BK_IDLE = 5'b00001,
		BK_SLOT = 5'b00010,
		BK_CMP  = 5'b00100,
		BK_CHK  = 5'b01000,
		BK_FIN  = 5'b10000
	} bk_state_t;

	bk_state_t      state_q;
	logic [7:0]     sig_mem [SD];
	logic [7:0]     hist_mem [HD];
	logic [LW-1:0]  lens_q [NS];
	logic [31:0]    cnt_q;
	logic [31:0]    cur_q;
	logic [HAW-1:0] wp_q;
	logic [HAW-1:0] k_q;
	logic [SIW-1:0] slot_q;
	logic           ok_q;
	logic           rd_vld_s1;
	logic [7:0]     sig_rd_s1;
	logic [7:0]     hist_rd_s1;
	logic           pend_vld_q;
	out_beat_t      pend_q;
	logic           out_valid_q;
	out_beat_t      out_q;

	logic [LW-1:0]      len_cur;
	logic [LW-1:0]      len_m1;
	logic               eligible;
	logic               k_last;
	logic               slot_end;
	logic               out_free;
	logic               byte_eq;
	logic               match_ok;
	logic               rd_en;
	logic [SIW+HAW-1:0] sig_raddr;
	logic [HAW-1:0]     hist_raddr;
	logic               push_out;
	logic               adv;
	out_beat_t          push_beat;
	out_beat_t          new_res;
	logic               take_scan;
	logic               take_load;

	always_comb begin
		len_cur    = lens_q[slot_q];
		len_m1     = len_cur - 1'b1;
		eligible   = (len_cur != '0) && (cur_q >= 32'(len_m1));
		k_last     = LW'(k_q) == len_m1;
		slot_end   = slot_q == SIW'(NS - 1);
		out_free   = !out_valid_q || out_ready;
		byte_eq    = sig_rd_s1 == hist_rd_s1;
		match_ok   = ok_q && byte_eq;
		rd_en      = state_q == BK_CMP;
		sig_raddr  = {slot_q, HAW'(len_m1 - LW'(k_q))};
		hist_raddr = wp_q - k_q;
		q_pop      = (state_q == BK_IDLE) && q_valid;
		take_scan  = q_pop && (q_op.kind == CMD_SCAN);
		take_load  = q_pop && (q_op.kind == CMD_LOAD);

		new_res.match_slot   = 3'(slot_q);
		new_res.start_offset = cur_q - 32'(len_m1);
		new_res.match_len    = 7'(len_cur);
		new_res.last         = 1'b0;

		push_out       = 1'b0;
		adv            = 1'b1;
		push_beat      = pend_q;
		push_beat.last = state_q == BK_FIN;
		if ((state_q == BK_CHK) && match_ok && pend_vld_q) begin
			push_out = 1'b1;
			adv      = out_free;
		end
		if ((state_q == BK_FIN) && pend_vld_q) begin
			push_out = 1'b1;
			adv      = out_free;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// signature store and history window
	always_ff @(posedge clk) begin
		if (take_load) begin
			sig_mem[{SIW'(q_op.slot), HAW'(q_op.pos)}] <= q_op.data;
		end
		if (rd_en) begin
			sig_rd_s1 <= sig_mem[sig_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (take_scan) begin
			hist_mem[wp_q + 1'b1] <= q_op.data;
		end
		if (rd_en) begin
			hist_rd_s1 <= hist_mem[hist_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (take_scan) begin
			cur_q <= cnt_q;
		end
		if ((state_q == BK_CHK) && match_ok && adv) begin
			pend_q <= new_res;
		end
		if (push_out && out_free) begin
			out_q <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			lens_q      <= '{default: '0};
			cnt_q       <= '0;
			wp_q        <= '0;
			k_q         <= '0;
			slot_q      <= '0;
			ok_q        <= 1'b0;
			rd_vld_s1   <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (push_out && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						unique case (q_op.kind)
							CMD_SET_LEN: begin
								lens_q[SIW'(q_op.slot)] <= LW'(q_op.len);
							end
							CMD_RESTART: begin
								cnt_q <= '0;
							end
							CMD_SCAN: begin
								wp_q    <= wp_q + 1'b1;
								cnt_q   <= (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
								slot_q  <= '0;
								state_q <= BK_SLOT;
							end
							default: begin
							end
						endcase
					end
				end
				BK_SLOT: begin
					if (eligible) begin
						k_q     <= '0;
						ok_q    <= 1'b1;
						state_q <= BK_CMP;
					end else if (slot_end) begin
						state_q <= BK_FIN;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				BK_CMP: begin
					if (rd_vld_s1 && !byte_eq) begin
						ok_q <= 1'b0;
					end
					k_q <= k_q + 1'b1;
					if (k_last) begin
						state_q <= BK_CHK;
					end
				end
				BK_CHK: begin
					if (adv) begin
						if (match_ok) begin
							pend_vld_q <= 1'b1;
						end
						if (slot_end) begin
							state_q <= BK_FIN;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= BK_SLOT;
						end
					end
				end
				BK_FIN: begin
					if (adv) begin
						pend_vld_q <= 1'b0;
						state_q    <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/multi_signature_byte_matcher.sv
// an accepted beat is registered in the command queue before the back end can pop it
// load, set-length and restart are done in the idle state; a scan walks the slots in
// order and compares each enabled slot whose window is full, then checks it; the
// single compare unit reads one signature byte and one history byte per cycle
// the two-entry queue and the output register let input and output stall separately
// reset: lengths, byte counter, pointers and handshakes clear; signature store undefined
module multi_signature_byte_matcher import msbm_pkg::*; #(
	parameter int NUM_SIGS    = NUM_SIGS_DEF,
	parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	logic q_push;
	op_t  q_wr_op;
	logic q_ready;
	logic q_valid;
	op_t  q_rd_op;
	logic q_pop;

	msbm_front #(
		.NUM_SIGS    (NUM_SIGS),
		.MAX_SIG_LEN (MAX_SIG_LEN)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (q_push),
		.op       (q_wr_op),
		.q_ready  (q_ready)
	);

	msbm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_op  (q_wr_op),
		.ready  (q_ready),
		.valid  (q_valid),
		.rd_op  (q_rd_op),
		.pop    (q_pop)
	);

	msbm_back #(
		.NUM_SIGS    (NUM_SIGS),
		.MAX_SIG_LEN (MAX_SIG_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_rd_op),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/msbm_checker.sv
// port checker for the matcher, attached to the top level by bind
// uses msbm_pkg
module msbm_checker import msbm_pkg::*; #(
	parameter int NUM_SIGS    = NUM_SIGS_DEF,
	parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	logic [32:0] end_offset;

	assign end_offset = {1'b0, out_data.start_offset} + 33'(out_data.match_len) - 33'd1;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat dropped or changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat dropped or changed while stalled");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.match_len != 7'd0) &&
			(32'(out_data.match_len) <= 32'(MAX_SIG_LEN)) &&
			(32'(out_data.match_slot) < 32'(NUM_SIGS)))
		else $error("match length or slot out of range");

	a_end_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> end_offset[32] == 1'b0)
		else $error("match runs past the byte counter");

endmodule

bind multi_signature_byte_matcher msbm_checker #(
	.NUM_SIGS    (NUM_SIGS),
	.MAX_SIG_LEN (MAX_SIG_LEN)
) u_msbm_checker (.*);
